@@ rtl/core/lgs_pkg.sv @@
// ----------------------------------------------------------------------------
// lgs_pkg
// Types, constants and the B3/S23 rule shared by the life generation stream.
// ----------------------------------------------------------------------------
`default_nettype none

package lgs_pkg;

	// configuration register file
	localparam int unsigned REG_W        = 11;
	localparam int unsigned ROW_W        = 11;
	localparam int unsigned MIN_SIDE     = 3;
	localparam int unsigned HEIGHT_LIMIT = 1024;

	typedef enum logic {
		REG_GRID_WIDTH  = 1'b0,
		REG_GRID_HEIGHT = 1'b1
	} lgs_reg_t;

	// input operation codes
	typedef enum logic {
		OP_CELL  = 1'b0,
		OP_FLUSH = 1'b1
	} lgs_op_t;

	// 3x3 window: bits 0..2 upper row, 3..5 middle row, 6..8 lower row,
	// lowest bit of each row is the oldest column
	localparam logic [8:0] WIN_KEEP    = 9'h0DB;
	localparam int unsigned WIN_CENTER = 4;
	localparam logic [8:0] MASK_TOP    = 9'h007;
	localparam logic [8:0] MASK_BOTTOM = 9'h1C0;
	localparam logic [8:0] MASK_LEFT   = 9'h049;
	localparam logic [8:0] MASK_RIGHT  = 9'h124;

	// control carried from the address stage to the window stage
	typedef struct packed {
		logic       produce;
		logic       last;
		logic [8:0] mask;
	} lgs_ctrl_t;

	function automatic logic life_rule(input logic [8:0] win);
		logic [3:0] count;
		count = 4'd0;
		for (int k = 0; k < 9; k++) begin
			if (k != WIN_CENTER) begin
				count = count + {3'b000, win[k]};
			end
		end
		return (count == 4'd3) || (win[WIN_CENTER] && (count == 4'd2));
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/lgs_stream_if.sv @@
// ----------------------------------------------------------------------------
// lgs stream interfaces
// Valid/ready channels for cells in and next-generation results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lgs_in_if;
	logic valid;
	logic ready;
	logic operation;
	logic cell_alive;

	modport source (output valid, output operation, output cell_alive, input ready);
	modport sink (input valid, input operation, input cell_alive, output ready);
endinterface

interface lgs_out_if;
	logic valid;
	logic ready;
	logic next_alive;
	logic frame_end;

	modport source (output valid, output next_alive, output frame_end, input ready);
	modport sink (input valid, input next_alive, input frame_end, output ready);
endinterface

`default_nettype wire

@@ rtl/core/lgs_line_store.sv @@
// ----------------------------------------------------------------------------
// lgs_line_store
// Two line buffers packed in one 2-bit wide memory, registered read,
// write-to-read bypass and a clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_line_store
	import lgs_pkg::*;
#(
	parameter int unsigned MAX_WIDTH = 1024,
	parameter int unsigned AW        = $clog2(MAX_WIDTH)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [1:0]    wr_data,
	output logic      [1:0]    rd_data,
	output logic               busy
);

	logic [1:0]    mem [MAX_WIDTH];
	logic [1:0]    rd_q;
	logic [1:0]    byp_data_q;
	logic          byp_q;
	logic [AW-1:0] clr_addr_q;
	logic          busy_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [1:0]    mem_wdata;

	always_comb begin
		mem_we    = busy_q || wr_en;
		mem_waddr = busy_q ? clr_addr_q : wr_addr;
		mem_wdata = busy_q ? 2'b00 : wr_data;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			byp_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
			byp_q      <= 1'b0;
		end else begin
			if (busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (32'(clr_addr_q) == MAX_WIDTH - 1) begin
					busy_q <= 1'b0;
				end
			end
			// same-address write in the read cycle: take the new data
			if (rd_en) begin
				byp_q <= wr_en && (wr_addr == rd_addr);
			end
		end
	end

	assign rd_data = byp_q ? byp_data_q : rd_q;
	assign busy    = busy_q;

endmodule

`default_nettype wire

@@ rtl/core/life_generation_stream_top.sv @@
// A result is held in the address stage register and then in the output register
// after the transaction that completes its window, one row and one column behind.
// Throughput: one cell transaction per cycle when no stall or clear holds it, set
// by the single-port-per-direction line store (one read and one write each cycle).
// Reset: registers go to 256x256 and the line store is swept clear, one entry
// per cycle over all MAX_WIDTH entries, with the input ready low until it is done.
// ----------------------------------------------------------------------------
// life_generation_stream_top
// One generation of B3/S23 life over a raster stream of cells.
// ----------------------------------------------------------------------------
`default_nettype none

module life_generation_stream_top
	import lgs_pkg::*;
#(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	lgs_in_if.sink           cell_in,
	lgs_out_if.source        cell_out
);

	localparam int unsigned AW = $clog2(MAX_WIDTH);

	// configuration registers
	logic [REG_W-1:0] grid_width_q;
	logic [REG_W-1:0] grid_height_q;
	logic             cfg_wr;
	lgs_reg_t         cfg_sel;

	// stream position of the next input transaction
	logic [AW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;

	// address stage
	logic             s1_valid_q;
	logic             v_s1;
	logic [AW-1:0]    x_s1;
	lgs_ctrl_t        ctrl_s1;

	// window and result register
	logic [8:0]       window_q;
	logic             out_valid_q;
	logic             next_alive_q;
	logic             frame_end_q;

	// line store
	logic [1:0]       ls_rd_data;
	logic             ls_busy;
	logic             ls_wr_en;

	// address stage logic
	logic [REG_W-1:0] w_eff;
	logic [REG_W-1:0] h_eff;
	logic [AW-1:0]    x_cur;
	logic             first_col;
	logic [ROW_W-1:0] need_rows;
	logic [ROW_W-1:0] cr;
	logic [REG_W-1:0] cc;
	lgs_ctrl_t        ctrl_cur;
	logic             accept;
	logic             s1_fire;
	logic [8:0]       win_next;
	logic [8:0]       win_masked;

	// ------------------------------------------------------------------
	// configuration port: writes restart the frame
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_sel = lgs_reg_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		unique case (cfg_sel)
			REG_GRID_WIDTH:  prdata = {{(32 - REG_W){1'b0}}, grid_width_q};
			REG_GRID_HEIGHT: prdata = {{(32 - REG_W){1'b0}}, grid_height_q};
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= REG_W'(256);
			grid_height_q <= REG_W'(256);
		end else if (cfg_wr) begin
			unique case (cfg_sel)
				REG_GRID_WIDTH:  grid_width_q  <= pwdata[REG_W-1:0];
				REG_GRID_HEIGHT: grid_height_q <= pwdata[REG_W-1:0];
				default:         grid_width_q  <= grid_width_q;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// address stage: position, edge masks, whether a result is due
	// ------------------------------------------------------------------
	always_comb begin
		// sides saturated into their legal ranges
		if (32'(grid_width_q) < MIN_SIDE) begin
			w_eff = REG_W'(MIN_SIDE);
		end else if (32'(grid_width_q) > MAX_WIDTH) begin
			w_eff = REG_W'(MAX_WIDTH);
		end else begin
			w_eff = grid_width_q;
		end
		if (32'(grid_height_q) < MIN_SIDE) begin
			h_eff = REG_W'(MIN_SIDE);
		end else if (32'(grid_height_q) > HEIGHT_LIMIT) begin
			h_eff = REG_W'(HEIGHT_LIMIT);
		end else begin
			h_eff = grid_height_q;
		end

		x_cur     = (32'(col_q) >= 32'(w_eff)) ? '0 : col_q;
		first_col = (x_cur == '0);

		// a first-column input closes the last column two rows up
		need_rows = first_col ? ROW_W'(2) : ROW_W'(1);
		cr        = row_q - need_rows;
		cc        = first_col ? (w_eff - 1'b1) : (REG_W'(x_cur) - 1'b1);

		ctrl_cur.produce = (row_q >= need_rows) && (32'(cr) < 32'(h_eff));
		ctrl_cur.last    = ctrl_cur.produce && (32'(cr) == 32'(h_eff) - 1)
			&& (cc == w_eff - 1'b1);
		ctrl_cur.mask    = '0;
		if (cr == '0) begin
			ctrl_cur.mask = ctrl_cur.mask | MASK_TOP;
		end
		if (32'(cr) == 32'(h_eff) - 1) begin
			ctrl_cur.mask = ctrl_cur.mask | MASK_BOTTOM;
		end
		if (cc == '0) begin
			ctrl_cur.mask = ctrl_cur.mask | MASK_LEFT;
		end
		if (cc == w_eff - 1'b1) begin
			ctrl_cur.mask = ctrl_cur.mask | MASK_RIGHT;
		end
	end

	// window stage moves on unless its result would land on a full register
	assign s1_fire = s1_valid_q && (!ctrl_s1.produce || !out_valid_q || cell_out.ready);
	assign cell_in.ready = !ls_busy && (!s1_valid_q || s1_fire);
	assign accept = cell_in.valid && cell_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			s1_valid_q <= 1'b0;
		end else if (cfg_wr) begin
			col_q      <= '0;
			row_q      <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
				if (ctrl_cur.last) begin
					col_q <= '0;
					row_q <= '0;
				end else if (32'(x_cur) + 1 >= 32'(w_eff)) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= x_cur + 1'b1;
				end
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	// flush transactions enter as dead cells
	always_ff @(posedge clk) begin
		if (accept) begin
			v_s1    <= (lgs_op_t'(cell_in.operation) == OP_FLUSH) ? 1'b0 : cell_in.cell_alive;
			x_s1    <= x_cur;
			ctrl_s1 <= ctrl_cur;
		end
	end

	// ------------------------------------------------------------------
	// line store: bit 0 is the upper row, bit 1 the middle row
	// ------------------------------------------------------------------
	assign ls_wr_en = s1_fire;

	lgs_line_store #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (x_cur),
		.wr_en   (ls_wr_en),
		.wr_addr (x_s1),
		.wr_data ({v_s1, ls_rd_data[1]}),
		.rd_data (ls_rd_data),
		.busy    (ls_busy)
	);

	// ------------------------------------------------------------------
	// window stage: shift in the new column, mask edges, apply the rule
	// ------------------------------------------------------------------
	always_comb begin
		win_next   = ((window_q >> 1) & WIN_KEEP)
			| {v_s1, 2'b00, ls_rd_data[1], 2'b00, ls_rd_data[0], 2'b00};
		win_masked = win_next & ~ctrl_s1.mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= '0;
			out_valid_q <= 1'b0;
		end else if (cfg_wr) begin
			window_q    <= '0;
		end else begin
			if (s1_fire) begin
				window_q <= win_next;
			end
			if (s1_fire && ctrl_s1.produce) begin
				out_valid_q <= 1'b1;
			end else if (cell_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && ctrl_s1.produce) begin
			next_alive_q <= life_rule(win_masked);
			frame_end_q  <= ctrl_s1.last;
		end
	end

	assign cell_out.valid      = out_valid_q;
	assign cell_out.next_alive = next_alive_q;
	assign cell_out.frame_end  = frame_end_q;

endmodule

`default_nettype wire

@@ bench/life_generation_stream_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// life_generation_stream_top_test
// Self-checking bench for the streaming B3/S23 generation block. A scoreboard
// class carries its own line stores and 3x3 window, predicts the next state
// of every cell from the accepted input stream and checks each result in
// order. Frames of many sizes, register edge values, early flushes, surplus
// padding cells and unaligned noise are sent with random stalls on both sides.
// ----------------------------------------------------------------------------

module life_generation_stream_top_test;
	import lgs_pkg::*;

	localparam int unsigned LINE_MAX      = 1024;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned RANDOM_ITEMS  = 560;
	localparam int unsigned TIMEOUT_NS    = 4_000_000;

	typedef struct packed {
		logic next_alive;
		logic frame_end;
	} life_result_t;

	// next-generation predictor and the queue of results it still owes
	class life_scoreboard;
		logic [REG_W-1:0] width_reg;
		logic [REG_W-1:0] height_reg;
		logic             upper_row [LINE_MAX];
		logic             middle_row [LINE_MAX];
		logic [8:0]       window;
		int unsigned      in_col;
		int unsigned      in_row;
		life_result_t     expected_next [$];
		int unsigned      failures;

		function new();
			width_reg  = REG_W'(256);
			height_reg = REG_W'(256);
			foreach (upper_row[i]) begin
				upper_row[i]  = 1'b0;
				middle_row[i] = 1'b0;
			end
			failures = 0;
			restart();
		endfunction

		function void restart();
			window = '0;
			in_col = 0;
			in_row = 0;
		endfunction

		function int unsigned clamp_side(int unsigned v, int unsigned hi);
			if (v < MIN_SIDE) return MIN_SIDE;
			if (v > hi) return hi;
			return v;
		endfunction

		function int unsigned grid_cols();
			return clamp_side(width_reg, LINE_MAX);
		endfunction

		function int unsigned grid_rows();
			return clamp_side(height_reg, HEIGHT_LIMIT);
		endfunction

		function bit at_frame_start();
			return (in_col == 0) && (in_row == 0);
		endfunction

		function int unsigned pending();
			return expected_next.size();
		endfunction

		// a write restarts the frame, the line stores keep their contents
		function void write_register(lgs_reg_t idx, logic [31:0] data);
			if (idx == REG_GRID_WIDTH) begin
				width_reg = data[REG_W-1:0];
			end else begin
				height_reg = data[REG_W-1:0];
			end
			restart();
		endfunction

		function void note_cell(lgs_op_t op, logic alive);
			int unsigned  w, h, x, need, cr, cc, neighbours;
			logic         v, top, mid, last;
			logic [8:0]   win;
			life_result_t res;
			w = grid_cols();
			h = grid_rows();
			v = (op == OP_FLUSH) ? 1'b0 : alive;
			x = (in_col >= w) ? 0 : in_col;
			top = upper_row[x];
			mid = middle_row[x];
			upper_row[x]  = mid;
			middle_row[x] = v;
			window = ((window >> 1) & WIN_KEEP) | {v, 2'b00, mid, 2'b00, top, 2'b00};
			last = 1'b0;
			// column zero finishes the last cell of the row two above
			need = (x == 0) ? 2 : 1;
			if (in_row >= need) begin
				cr = in_row - need;
				cc = (x == 0) ? w - 1 : x - 1;
				if (cr < h) begin
					win = window;
					if (cr == 0) win = win & ~MASK_TOP;
					if (cr == h - 1) win = win & ~MASK_BOTTOM;
					if (cc == 0) win = win & ~MASK_LEFT;
					if (cc == w - 1) win = win & ~MASK_RIGHT;
					neighbours = 0;
					for (int k = 0; k < 9; k++) begin
						if (k != WIN_CENTER) neighbours += win[k];
					end
					last = (cr == h - 1) && (cc == w - 1);
					res.next_alive = (neighbours == 3) || (win[WIN_CENTER] && neighbours == 2);
					res.frame_end  = last;
					expected_next.push_back(res);
				end
			end
			if (last) begin
				in_col = 0;
				in_row = 0;
			end else if (x + 1 >= w) begin
				in_col = 0;
				in_row = (in_row + 1) & 32'h7FF;
			end else begin
				in_col = x + 1;
			end
		endfunction

		function void check_result(logic next_alive, logic frame_end);
			life_result_t want;
			if (expected_next.size() == 0) begin
				$error("unexpected result: next_alive %0b frame_end %0b", next_alive, frame_end);
				failures++;
				return;
			end
			want = expected_next.pop_front();
			if (next_alive !== want.next_alive) begin
				$error("next_alive: expected %0b, actual %0b", want.next_alive, next_alive);
				failures++;
			end
			if (frame_end !== want.frame_end) begin
				$error("frame_end: expected %0b, actual %0b", want.frame_end, frame_end);
				failures++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	lgs_in_if  cell_in_bus ();
	lgs_out_if cell_out_bus ();

	life_scoreboard board = new();

	// calm turns all random idling off for a stretch
	bit          calm;
	// tracks whether valid is currently driven high
	bit          offering;
	int unsigned items_sent;

	life_generation_stream_top #(
		.MAX_WIDTH (LINE_MAX)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.cell_in  (cell_in_bus),
		.cell_out (cell_out_bus)
	);

	// 4 ns clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// hard stop in case a handshake never completes
	initial begin
		#(TIMEOUT_NS);
		$display("[FAIL] regression broken");
		$finish;
	end

	// result side: check every accepted transaction, stall ready at random
	initial begin : result_sink
		int unsigned stall, r;
		stall = 0;
		cell_out_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (cell_out_bus.valid === 1'b1 && cell_out_bus.ready === 1'b1) begin
				board.check_result(cell_out_bus.next_alive, cell_out_bus.frame_end);
			end
			if (stall != 0) begin
				stall--;
				cell_out_bus.ready <= 1'b0;
			end else if (calm) begin
				cell_out_bus.ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 75) begin
					cell_out_bus.ready <= 1'b1;
				end else begin
					// mostly short stalls, a few long ones
					stall = (r < 97) ? $urandom_range(1, 3) : $urandom_range(8, 40);
					stall--;
					cell_out_bus.ready <= 1'b0;
				end
			end
		end
	end

	// offer one cell transaction and hold it until accepted; valid stays high
	// so the next call can follow back to back
	task automatic send_item(lgs_op_t op, logic alive);
		cell_in_bus.valid      <= 1'b1;
		cell_in_bus.operation  <= op;
		cell_in_bus.cell_alive <= alive;
		offering = 1'b1;
		do @(posedge clk); while (cell_in_bus.ready !== 1'b1);
		board.note_cell(op, alive);
		items_sent++;
	endtask

	task automatic lower_valid();
		if (offering) begin
			cell_in_bus.valid <= 1'b0;
			offering = 1'b0;
		end
	endtask

	// random gap between input transactions
	task automatic sender_pause();
		int unsigned r, gap;
		if (calm) return;
		r = $urandom_range(0, 99);
		if (r < 70) return;
		gap = (r < 97) ? $urandom_range(1, 3) : $urandom_range(8, 40);
		lower_valid();
		repeat (gap) @(posedge clk);
	endtask

	// hold the input until every predicted result is out, then let the
	// pipeline run dry for the settle time
	task automatic drain(int unsigned settle);
		lower_valid();
		do @(posedge clk); while (board.pending() != 0);
		repeat (settle) @(posedge clk);
	endtask

	// two-phase register write, setup then access
	task automatic reg_write(lgs_reg_t idx, int unsigned value);
		logic [31:0] data;
		// upper data bits are junk the register must drop
		data = ($urandom() & ~32'h7FF) | (value & 32'h7FF);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		board.write_register(idx, data);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(int unsigned w, int unsigned h);
		drain(SETTLE_CYCLES);
		reg_write(REG_GRID_WIDTH, w);
		reg_write(REG_GRID_HEIGHT, h);
	endtask

	// mostly small grids, some wider or taller, a few below the legal range
	task automatic pick_setting();
		int unsigned w, h, r;
		r = $urandom_range(0, 15);
		if (r == 0) w = $urandom_range(0, 2);
		else if (r < 3) w = $urandom_range(11, 24);
		else w = $urandom_range(3, 10);
		r = $urandom_range(0, 15);
		if (r == 0) h = $urandom_range(0, 2);
		else if (r < 3) h = $urandom_range(9, 14);
		else h = $urandom_range(3, 8);
		drain(SETTLE_CYCLES);
		// a single write is enough to restart the frame
		r = $urandom_range(0, 3);
		if (r == 0) begin
			reg_write(REG_GRID_WIDTH, w);
		end else if (r == 1) begin
			reg_write(REG_GRID_HEIGHT, h);
		end else begin
			reg_write(REG_GRID_WIDTH, w);
			reg_write(REG_GRID_HEIGHT, h);
		end
	endtask

	// a short run of random cells that need not line up with a frame
	task automatic send_cells(int unsigned count);
		repeat (count) begin
			send_item(OP_CELL, 1'($urandom_range(0, 1)));
			sender_pause();
		end
	endtask

	// one whole frame plus its width+1 padding transactions; a quirky frame
	// swaps in early flushes and surplus cells in the padding
	task automatic send_frame(int unsigned density, bit quirky);
		int unsigned w, h;
		lgs_op_t     op;
		logic        alive;
		w = board.grid_cols();
		h = board.grid_rows();
		for (int unsigned i = 0; i < w * h; i++) begin
			op    = OP_CELL;
			alive = ($urandom_range(0, 99) < density);
			if (quirky && $urandom_range(0, 39) == 0) begin
				op    = OP_FLUSH;
				alive = 1'($urandom_range(0, 1));
			end
			send_item(op, alive);
			// now and then the sender waits for the output to catch up
			if ($urandom_range(0, 299) == 0) drain(0);
			else sender_pause();
		end
		for (int unsigned i = 0; i <= w; i++) begin
			op    = OP_FLUSH;
			alive = 1'($urandom_range(0, 1));
			if (quirky && $urandom_range(0, 7) == 0) op = OP_CELL;
			send_item(op, alive);
			sender_pause();
		end
	endtask

	initial begin : stimulus
		int unsigned random_base, kind, burst;
		calm       = 1'b0;
		offering   = 1'b0;
		items_sent = 0;
		arst_n                 <= 1'b0;
		psel                   <= 1'b0;
		penable                <= 1'b0;
		pwrite                 <= 1'b0;
		paddr                  <= '0;
		pwdata                 <= '0;
		cell_in_bus.valid      <= 1'b0;
		cell_in_bus.operation  <= OP_CELL;
		cell_in_bus.cell_alive <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// the line store clear runs with ready low
		do @(posedge clk); while (cell_in_bus.ready !== 1'b1);

		// directed: smallest grid, vertical blinker in the middle column
		apply_setting(3, 3);
		for (int unsigned i = 0; i < 9; i++) begin
			// early flush with a live bit stands in for the dead corner cell
			if (i == 0) send_item(OP_FLUSH, 1'b1);
			else send_item(OP_CELL, (i % 3) == 1);
			// one full stop mid frame until the output drains
			if (i == 4) drain(0);
			else sender_pause();
		end
		for (int unsigned i = 0; i < 4; i++) begin
			// a live cell in the padding lies outside the grid
			if (i == 2) send_item(OP_CELL, 1'b1);
			else send_item(OP_FLUSH, 1'b0);
			sender_pause();
		end

		// directed: a register write in the middle of a frame restarts it
		for (int unsigned i = 0; i < 4; i++) begin
			send_item(OP_CELL, 1'b1);
		end
		apply_setting(4, 5);

		// extreme settings: widest row, out of range values on both registers
		apply_setting(1024, 0);
		send_cells(24);
		apply_setting(2, 2047);
		send_cells(40);
		apply_setting(2047, 3);
		send_cells(24);

		// back to a small grid before the random phases
		apply_setting(5, 4);
		send_frame(50, 1'b1);

		// random phases
		random_base = items_sent;
		while (items_sent - random_base < RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 3) == 0) begin
				pick_setting();
			end else if (!board.at_frame_start()) begin
				// rewrite the width to line the stream up with a frame again
				drain(SETTLE_CYCLES);
				reg_write(REG_GRID_WIDTH, board.width_reg);
			end
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				send_frame($urandom_range(10, 90), $urandom_range(0, 3) == 0);
			end else if (kind < 9) begin
				// unaligned noise with a mix of both operations
				burst = $urandom_range(5, 40);
				repeat (burst) begin
					send_item(($urandom_range(0, 9) < 7) ? OP_CELL : OP_FLUSH,
						1'($urandom_range(0, 1)));
					sender_pause();
				end
			end else begin
				// frame cut short, picked up by the restart above
				burst = $urandom_range(1, board.grid_cols() * board.grid_rows() - 1);
				send_cells(burst);
			end
		end

		calm = 1'b0;
		drain(4 * SETTLE_CYCLES);
		if (board.failures == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/lgs_pkg.sv
rtl/core/lgs_stream_if.sv
rtl/core/lgs_line_store.sv
rtl/core/life_generation_stream_top.sv
bench/life_generation_stream_top_test.sv
